// ===== rtl/terminal_input_sequence_parser_unit_defines.svh =====
// Assertion macros shared by the terminal input sequence parser RTL.
`ifndef TERMINAL_INPUT_SEQUENCE_PARSER_UNIT_DEFINES_SVH
`define TERMINAL_INPUT_SEQUENCE_PARSER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define TISP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that, when seen, must be followed by a consequence in the next cycle.
`define TISP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TISP_ASSERT(lbl, clk, rst, prop, msg)
`define TISP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/tisp_pkg.sv =====
// Types and constants shared by the terminal input sequence parser.
package tisp_pkg;

  // Result status codes.
  localparam logic [2:0] ST_INCOMPLETE = 3'd0;
  localparam logic [2:0] ST_CONTROL    = 3'd1;
  localparam logic [2:0] ST_CHAR       = 3'd2;
  localparam logic [2:0] ST_UNKNOWN    = 3'd3;
  localparam logic [2:0] ST_EVENT      = 3'd4;

  // Event kinds.
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_KEY    = 2'd1;
  localparam logic [1:0] EV_MOUSE  = 2'd2;
  localparam logic [1:0] EV_CURSOR = 2'd3;

  // Key codes.
  localparam logic [4:0] KEY_UP     = 5'd0;
  localparam logic [4:0] KEY_DOWN   = 5'd1;
  localparam logic [4:0] KEY_RIGHT  = 5'd2;
  localparam logic [4:0] KEY_LEFT   = 5'd3;
  localparam logic [4:0] KEY_HOME   = 5'd4;
  localparam logic [4:0] KEY_END    = 5'd5;
  localparam logic [4:0] KEY_INSERT = 5'd6;
  localparam logic [4:0] KEY_DELETE = 5'd7;
  localparam logic [4:0] KEY_PGUP   = 5'd8;
  localparam logic [4:0] KEY_PGDN   = 5'd9;
  localparam logic [4:0] KEY_F1     = 5'd10;
  localparam logic [4:0] KEY_F2     = 5'd11;
  localparam logic [4:0] KEY_F3     = 5'd12;
  localparam logic [4:0] KEY_F4     = 5'd13;
  localparam logic [4:0] KEY_F5     = 5'd14;
  localparam logic [4:0] KEY_F6     = 5'd15;
  localparam logic [4:0] KEY_F7     = 5'd16;
  localparam logic [4:0] KEY_F8     = 5'd17;
  localparam logic [4:0] KEY_F9     = 5'd18;
  localparam logic [4:0] KEY_F10    = 5'd19;
  localparam logic [4:0] KEY_F11    = 5'd20;
  localparam logic [4:0] KEY_F12    = 5'd21;

  // Characters of interest in the byte stream.
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_SIX    = 8'h36;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UP     = 8'h41;
  localparam logic [7:0] CH_DOWN   = 8'h42;
  localparam logic [7:0] CH_RIGHT  = 8'h43;
  localparam logic [7:0] CH_LEFT   = 8'h44;
  localparam logic [7:0] CH_END    = 8'h46;
  localparam logic [7:0] CH_HOME   = 8'h48;
  localparam logic [7:0] CH_MOUSE  = 8'h4D;
  localparam logic [7:0] CH_SS3    = 8'h4F;
  localparam logic [7:0] CH_FKEY_P = 8'h50;
  localparam logic [7:0] CH_FKEY_S = 8'h53;
  localparam logic [7:0] CH_REPORT = 8'h52;
  localparam logic [7:0] CH_CSI    = 8'h5B;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  // UTF-8 lead and continuation masks.
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;

  // One result item.
  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  event_kind;
    logic [4:0]  key_code;
    logic [7:0]  mouse_button;
    logic [20:0] mouse_x;
    logic [20:0] mouse_y;
    logic [15:0] cursor_row;
    logic [15:0] cursor_col;
    logic [2:0]  char_length;
  } result_t;

endpackage

// ===== rtl/tisp_in_stage.sv =====
// Input register that holds one byte from the input stream until it is decoded.
module tisp_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       take,
  output logic       data_valid,
  output logic [7:0] data_q
);

  // The register is free when empty or when its byte is being decoded this cycle.
  assign s_tready = !data_valid || take;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      data_valid <= 1'b1;
    end else if (take) begin
      data_valid <= 1'b0;
    end
  end

  // Byte capture on each input transfer.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      data_q <= s_tdata;
    end
  end

endmodule

// ===== rtl/tisp_decoder.sv =====
// Sequence parser state and the per-byte decode logic.
`include "terminal_input_sequence_parser_unit_defines.svh"

module tisp_decoder #(
  parameter int MAX_SEQ_LEN = 16,
  parameter int NUM_WIDTH   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         in_byte,
  output tisp_pkg::result_t  res
);

  localparam int CW = $clog2(MAX_SEQ_LEN + 1);

  // Parser phases.
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_UTF8  = 4'd1;
  localparam logic [3:0] PH_ESC   = 4'd2;
  localparam logic [3:0] PH_SS3   = 4'd3;
  localparam logic [3:0] PH_CSI   = 4'd4;
  localparam logic [3:0] PH_KEY1  = 4'd5;
  localparam logic [3:0] PH_KEY2  = 4'd6;
  localparam logic [3:0] PH_ROW   = 4'd7;
  localparam logic [3:0] PH_COL   = 4'd8;
  localparam logic [3:0] PH_MCB   = 4'd9;
  localparam logic [3:0] PH_MCB_C = 4'd10;
  localparam logic [3:0] PH_MX    = 4'd11;
  localparam logic [3:0] PH_MX_C  = 4'd12;
  localparam logic [3:0] PH_MY    = 4'd13;
  localparam logic [3:0] PH_MY_C  = 4'd14;

  // Control state.
  logic [3:0]           phase, phase_next;
  logic [CW-1:0]        pending_count, pending_count_next;
  logic                 num_over, num_over_next;
  logic                 col_seen, col_seen_next;

  // Sequence payload state, always written before it is read.
  logic [1:0]           utf8_left, utf8_left_next;
  logic [2:0]           utf8_len, utf8_len_next;
  logic                 utf8_bad, utf8_bad_next;
  logic [2:0]           lead_digit, lead_digit_next;
  logic [3:0]           second_digit, second_digit_next;
  logic [7:0]           held_button, held_button_next;
  logic [20:0]          coord_accum, coord_accum_next;
  logic [20:0]          held_x, held_x_next;
  logic [NUM_WIDTH-1:0] row_accum, row_accum_next;
  logic [NUM_WIDTH-1:0] col_accum, col_accum_next;

  // Decode helpers.
  logic [CW:0]          count;
  logic                 lead_ok;
  logic [1:0]           lead_need;
  logic [6:0]           lead_val;
  logic [20:0]          cont_accum;
  logic                 cont_bad;
  logic                 cont_done;
  logic                 is_digit;
  logic [NUM_WIDTH:0]   row_add;
  logic [NUM_WIDTH:0]   col_add;
  logic                 do_row;

  // Multiply by ten and add a digit, saturating; the top bit flags overflow.
  function automatic logic [NUM_WIDTH:0] add_digit(input logic [NUM_WIDTH-1:0] acc,
                                                   input logic [3:0] d);
    logic [NUM_WIDTH+3:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (NUM_WIDTH + 4)'(d);
    if (v[NUM_WIDTH+3:NUM_WIDTH] != 4'd0) begin
      return {1'b1, {NUM_WIDTH{1'b1}}};
    end
    return {1'b0, v[NUM_WIDTH-1:0]};
  endfunction

  // Second digit that forms a function key after a lead of one or two.
  function automatic logic fkey_ok(input logic [2:0] lead, input logic [3:0] d);
    logic ok;
    ok = 1'b0;
    if (lead == 3'd1) begin
      ok = (d >= 4'd1) && (d <= 4'd9) && (d != 4'd6);
    end else if (lead == 3'd2) begin
      ok = (d == 4'd0) || (d == 4'd1) || (d == 4'd3) || (d == 4'd4);
    end
    return ok;
  endfunction

  // Function key for a two-digit tilde sequence.
  function automatic logic [4:0] fkey_code(input logic [2:0] lead, input logic [3:0] d);
    logic [4:0] k;
    k = tisp_pkg::KEY_F1;
    if (lead == 3'd1) begin
      case (d)
        4'd2:    k = tisp_pkg::KEY_F2;
        4'd3:    k = tisp_pkg::KEY_F3;
        4'd4:    k = tisp_pkg::KEY_F4;
        4'd5:    k = tisp_pkg::KEY_F5;
        4'd7:    k = tisp_pkg::KEY_F6;
        4'd8:    k = tisp_pkg::KEY_F7;
        4'd9:    k = tisp_pkg::KEY_F8;
        default: k = tisp_pkg::KEY_F1;
      endcase
    end else begin
      case (d)
        4'd1:    k = tisp_pkg::KEY_F10;
        4'd3:    k = tisp_pkg::KEY_F11;
        4'd4:    k = tisp_pkg::KEY_F12;
        default: k = tisp_pkg::KEY_F9;
      endcase
    end
    return k;
  endfunction

  // Editing key for a single-digit tilde sequence.
  function automatic logic [4:0] tilde_code(input logic [2:0] lead);
    logic [4:0] k;
    case (lead)
      3'd2:    k = tisp_pkg::KEY_INSERT;
      3'd3:    k = tisp_pkg::KEY_DELETE;
      3'd4:    k = tisp_pkg::KEY_END;
      3'd5:    k = tisp_pkg::KEY_PGUP;
      3'd6:    k = tisp_pkg::KEY_PGDN;
      default: k = tisp_pkg::KEY_HOME;
    endcase
    return k;
  endfunction

  // Byte count of the pending sequence including this byte.
  assign count = {1'b0, pending_count} + {{CW{1'b0}}, 1'b1};

  // UTF-8 lead classification.
  always_comb begin
    lead_ok   = 1'b1;
    lead_need = 2'd0;
    lead_val  = in_byte[6:0];
    if ((in_byte & tisp_pkg::ASCII_MASK) == 8'h00) begin
      lead_need = 2'd0;
    end else if ((in_byte & tisp_pkg::LEAD2_MASK) == tisp_pkg::LEAD2_TAG) begin
      lead_need = 2'd1;
      lead_val  = {2'b00, in_byte[4:0]};
    end else if ((in_byte & tisp_pkg::LEAD3_MASK) == tisp_pkg::LEAD3_TAG) begin
      lead_need = 2'd2;
      lead_val  = {3'b000, in_byte[3:0]};
    end else if ((in_byte & tisp_pkg::LEAD4_MASK) == tisp_pkg::LEAD4_TAG) begin
      lead_need = 2'd3;
      lead_val  = {4'b0000, in_byte[2:0]};
    end else begin
      lead_ok = 1'b0;
    end
  end

  // Continuation byte handling and decimal digit steps.
  assign cont_accum = {coord_accum[14:0], in_byte[5:0]};
  assign cont_bad   = utf8_bad || ((in_byte & tisp_pkg::CONT_MASK) != tisp_pkg::CONT_TAG);
  assign cont_done  = (utf8_left == 2'd1);
  assign is_digit   = (in_byte >= tisp_pkg::CH_ZERO) && (in_byte <= tisp_pkg::CH_NINE);
  assign row_add    = add_digit(row_accum, in_byte[3:0]);
  assign col_add    = add_digit(col_accum, in_byte[3:0]);

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_next         = phase;
    pending_count_next = pending_count;
    num_over_next      = num_over;
    col_seen_next      = col_seen;
    utf8_left_next     = utf8_left;
    utf8_len_next      = utf8_len;
    utf8_bad_next      = utf8_bad;
    lead_digit_next    = lead_digit;
    second_digit_next  = second_digit;
    held_button_next   = held_button;
    coord_accum_next   = coord_accum;
    held_x_next        = held_x;
    row_accum_next     = row_accum;
    col_accum_next     = col_accum;
    do_row             = 1'b0;
    res                = '0;
    res.status         = tisp_pkg::ST_INCOMPLETE;

    unique case (phase) inside
      PH_IDLE: begin
        if (in_byte == tisp_pkg::CH_ESC) begin
          phase_next = PH_ESC;
        end else if (in_byte < tisp_pkg::CH_SPACE || in_byte == tisp_pkg::CH_DEL) begin
          res.status = tisp_pkg::ST_CONTROL;
        end else if (!lead_ok) begin
          res.status = tisp_pkg::ST_UNKNOWN;
        end else if (lead_need == 2'd0) begin
          res.status      = tisp_pkg::ST_CHAR;
          res.char_length = 3'd1;
        end else begin
          phase_next       = PH_UTF8;
          coord_accum_next = 21'(lead_val);
          utf8_left_next   = lead_need;
          utf8_len_next    = {1'b0, lead_need} + 3'd1;
          utf8_bad_next    = 1'b0;
        end
      end
      PH_UTF8, PH_MCB_C: begin
        // A multi-byte button byte ends the mouse report as a character, or as unknown if malformed.
        coord_accum_next = cont_accum;
        utf8_left_next   = utf8_left - 2'd1;
        utf8_bad_next    = cont_bad;
        if (cont_done) begin
          if (cont_bad) begin
            res.status = tisp_pkg::ST_UNKNOWN;
          end else begin
            res.status      = tisp_pkg::ST_CHAR;
            res.char_length = utf8_len;
          end
        end
      end
      PH_ESC: begin
        if (in_byte == tisp_pkg::CH_CSI) begin
          phase_next = PH_CSI;
        end else if (in_byte == tisp_pkg::CH_SS3) begin
          phase_next = PH_SS3;
        end else begin
          res.status = tisp_pkg::ST_UNKNOWN;
        end
      end
      PH_SS3: begin
        if (in_byte >= tisp_pkg::CH_FKEY_P && in_byte <= tisp_pkg::CH_FKEY_S) begin
          res.status     = tisp_pkg::ST_EVENT;
          res.event_kind = tisp_pkg::EV_KEY;
          res.key_code   = tisp_pkg::KEY_F1 + 5'(in_byte - tisp_pkg::CH_FKEY_P);
        end else begin
          res.status = tisp_pkg::ST_UNKNOWN;
        end
      end
      PH_CSI: begin
        res.event_kind = tisp_pkg::EV_KEY;
        res.status     = tisp_pkg::ST_EVENT;
        case (in_byte)
          tisp_pkg::CH_UP:    res.key_code = tisp_pkg::KEY_UP;
          tisp_pkg::CH_DOWN:  res.key_code = tisp_pkg::KEY_DOWN;
          tisp_pkg::CH_RIGHT: res.key_code = tisp_pkg::KEY_RIGHT;
          tisp_pkg::CH_LEFT:  res.key_code = tisp_pkg::KEY_LEFT;
          tisp_pkg::CH_HOME:  res.key_code = tisp_pkg::KEY_HOME;
          tisp_pkg::CH_END:   res.key_code = tisp_pkg::KEY_END;
          default: begin
            res.event_kind = tisp_pkg::EV_NONE;
            res.status     = tisp_pkg::ST_INCOMPLETE;
            if (in_byte == tisp_pkg::CH_MOUSE) begin
              phase_next = PH_MCB;
            end else if (in_byte >= tisp_pkg::CH_ONE && in_byte <= tisp_pkg::CH_SIX) begin
              // A row led by zero or seven to nine is not taken here.
              lead_digit_next = in_byte[2:0];
              row_accum_next  = NUM_WIDTH'(in_byte[3:0]);
              phase_next      = PH_KEY1;
            end else begin
              res.status = tisp_pkg::ST_UNKNOWN;
            end
          end
        endcase
      end
      PH_KEY1: begin
        if (in_byte == tisp_pkg::CH_TILDE) begin
          res.status     = tisp_pkg::ST_EVENT;
          res.event_kind = tisp_pkg::EV_KEY;
          res.key_code   = tilde_code(lead_digit);
        end else if (is_digit && fkey_ok(lead_digit, in_byte[3:0])) begin
          second_digit_next = in_byte[3:0];
          row_accum_next    = row_add[NUM_WIDTH-1:0];
          num_over_next     = num_over || row_add[NUM_WIDTH];
          phase_next        = PH_KEY2;
        end else begin
          do_row = 1'b1;
        end
      end
      PH_KEY2: begin
        if (in_byte == tisp_pkg::CH_TILDE) begin
          res.status     = tisp_pkg::ST_EVENT;
          res.event_kind = tisp_pkg::EV_KEY;
          res.key_code   = fkey_code(lead_digit, second_digit);
        end else begin
          do_row = 1'b1;
        end
      end
      PH_ROW: begin
        do_row = 1'b1;
      end
      PH_COL: begin
        if (in_byte == tisp_pkg::CH_REPORT) begin
          if (!col_seen || num_over) begin
            res.status = tisp_pkg::ST_UNKNOWN;
          end else begin
            res.status     = tisp_pkg::ST_EVENT;
            res.event_kind = tisp_pkg::EV_CURSOR;
            res.cursor_row = 16'(row_accum);
            res.cursor_col = 16'(col_accum);
          end
        end else if (is_digit) begin
          col_accum_next = col_add[NUM_WIDTH-1:0];
          num_over_next  = num_over || col_add[NUM_WIDTH];
          col_seen_next  = 1'b1;
        end else begin
          res.status = tisp_pkg::ST_UNKNOWN;
        end
      end
      PH_MCB: begin
        held_button_next = in_byte;
        if (!lead_ok) begin
          res.status = tisp_pkg::ST_UNKNOWN;
        end else begin
          coord_accum_next = 21'(lead_val);
          utf8_left_next   = lead_need;
          utf8_len_next    = {1'b0, lead_need} + 3'd1;
          utf8_bad_next    = 1'b0;
          phase_next       = (lead_need == 2'd0) ? PH_MX : PH_MCB_C;
        end
      end
      PH_MX, PH_MY: begin
        if (!lead_ok) begin
          res.status = tisp_pkg::ST_UNKNOWN;
        end else begin
          coord_accum_next = 21'(lead_val);
          utf8_left_next   = lead_need;
          utf8_len_next    = {1'b0, lead_need} + 3'd1;
          utf8_bad_next    = 1'b0;
          if (lead_need != 2'd0) begin
            phase_next = (phase == PH_MX) ? PH_MX_C : PH_MY_C;
          end else if (phase == PH_MX) begin
            held_x_next = 21'(lead_val);
            phase_next  = PH_MY;
          end else begin
            res.status       = tisp_pkg::ST_EVENT;
            res.event_kind   = tisp_pkg::EV_MOUSE;
            res.mouse_button = held_button;
            res.mouse_x      = held_x;
            res.mouse_y      = 21'(lead_val);
          end
        end
      end
      PH_MX_C, PH_MY_C: begin
        coord_accum_next = cont_accum;
        utf8_left_next   = utf8_left - 2'd1;
        utf8_bad_next    = cont_bad;
        if (cont_done) begin
          if (cont_bad) begin
            res.status = tisp_pkg::ST_UNKNOWN;
          end else if (phase == PH_MX_C) begin
            held_x_next = cont_accum;
            phase_next  = PH_MY;
          end else begin
            res.status       = tisp_pkg::ST_EVENT;
            res.event_kind   = tisp_pkg::EV_MOUSE;
            res.mouse_button = held_button;
            res.mouse_x      = held_x;
            res.mouse_y      = cont_accum;
          end
        end
      end
      default: begin
        res.status = tisp_pkg::ST_UNKNOWN;
      end
    endcase

    // Shared handling of a cursor row byte after its first digit.
    if (do_row) begin
      if (in_byte == tisp_pkg::CH_SEMI) begin
        phase_next     = PH_COL;
        col_accum_next = '0;
        col_seen_next  = 1'b0;
      end else if (is_digit) begin
        row_accum_next = row_add[NUM_WIDTH-1:0];
        num_over_next  = num_over || row_add[NUM_WIDTH];
        phase_next     = PH_ROW;
      end else begin
        res.status = tisp_pkg::ST_UNKNOWN;
      end
    end

    // An over-long sequence is unknown whatever it held.
    if (count > (CW + 1)'(MAX_SEQ_LEN)) begin
      res        = '0;
      res.status = tisp_pkg::ST_UNKNOWN;
    end

    // Any final status drops the pending sequence.
    if (res.status != tisp_pkg::ST_INCOMPLETE) begin
      phase_next         = PH_IDLE;
      pending_count_next = '0;
      num_over_next      = 1'b0;
      col_seen_next      = 1'b0;
    end else begin
      pending_count_next = count[CW-1:0];
    end
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      pending_count <= '0;
      num_over      <= 1'b0;
      col_seen      <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      pending_count <= pending_count_next;
      num_over      <= num_over_next;
      col_seen      <= col_seen_next;
    end
  end

  // Payload state registers.
  always_ff @(posedge clk) begin
    if (step) begin
      utf8_left    <= utf8_left_next;
      utf8_len     <= utf8_len_next;
      utf8_bad     <= utf8_bad_next;
      lead_digit   <= lead_digit_next;
      second_digit <= second_digit_next;
      held_button  <= held_button_next;
      coord_accum  <= coord_accum_next;
      held_x       <= held_x_next;
      row_accum    <= row_accum_next;
      col_accum    <= col_accum_next;
    end
  end

  // Checks on the parser.
  `TISP_ASSERT_NEXT(a_clear_after_result, clk, rst, step && res.status != tisp_pkg::ST_INCOMPLETE, phase == PH_IDLE && pending_count == '0, "sequence not cleared after a final status")
  `TISP_ASSERT_NEXT(a_count_steps, clk, rst, step && res.status == tisp_pkg::ST_INCOMPLETE, pending_count == $past(pending_count) + 1'b1, "pending count did not advance")
  `TISP_ASSERT(a_event_kind, clk, rst, !step || ((res.status == tisp_pkg::ST_EVENT) == (res.event_kind != tisp_pkg::EV_NONE)), "event kind disagrees with status")
  `TISP_ASSERT(a_char_length, clk, rst, !step || ((res.status == tisp_pkg::ST_CHAR) == (res.char_length != 3'd0)), "character length disagrees with status")

endmodule

// ===== rtl/tisp_out_stage.sv =====
// Result register that holds one decoded result until the receiver takes it.
module tisp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tisp_pkg::result_t res_in,
  input  logic              m_tready,
  output logic              m_tvalid,
  output tisp_pkg::result_t res_q,
  output logic              room
);

  // A new result may enter when the register is empty or being emptied.
  assign room = !m_tvalid || m_tready;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result capture.
  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

endmodule

// ===== rtl/terminal_input_sequence_parser_unit.sv =====
// Top level of the terminal input sequence parser.
//
// Raw terminal bytes enter on the s_ stream, one byte per transfer. For every
// byte exactly one result leaves on the m_ stream: incomplete, control byte,
// UTF-8 character, unknown, or a decoded key, mouse or cursor report event.
// The status and event kind travel in m_tuser, all other result fields in
// m_tdata.
// A byte accepted into the input register is decoded into the result register
// once that register has room, and its result is then offered on the m_ stream.
// Throughput: one byte per cycle while results are taken, set by the parser
// state register update between the input register and the result register.
// The input register takes a new byte while a finished result still waits.
// When the receiver stalls, the result register holds its transfer, one more
// byte waits in the input register and s_tready then falls.
// Synchronous reset empties both registers and returns the parser to idle
// with no pending sequence; no clearing pass is needed.
module terminal_input_sequence_parser_unit #(
  parameter int MAX_SEQ_LEN = 16,
  parameter int NUM_WIDTH   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // key_code[4:0], mouse_button[12:5], mouse_x[33:13],
                                 // mouse_y[54:34], cursor_row[70:55], cursor_col[86:71],
                                 // char_length[89:87], zero[95:90]
  output logic [4:0]  m_tuser    // status[2:0], event_kind[4:3]
);

  logic              data_valid;
  logic [7:0]        data_q;
  logic              room;
  logic              step;
  tisp_pkg::result_t res;
  tisp_pkg::result_t res_q;

  // A byte is decoded when it is held and the result register has room.
  assign step = data_valid && room;

  tisp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .take       (step),
    .data_valid (data_valid),
    .data_q     (data_q)
  );

  tisp_decoder #(
    .MAX_SEQ_LEN (MAX_SEQ_LEN),
    .NUM_WIDTH   (NUM_WIDTH)
  ) u_decoder (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (data_q),
    .res     (res)
  );

  tisp_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .res_in   (res),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .res_q    (res_q),
    .room     (room)
  );

  // Result packing onto the output stream.
  assign m_tdata = {6'b000000, res_q.char_length, res_q.cursor_col, res_q.cursor_row,
                    res_q.mouse_y, res_q.mouse_x, res_q.mouse_button, res_q.key_code};
  assign m_tuser = {res_q.event_kind, res_q.status};

endmodule
